// File: sv/scfd_pkg.sv
// Package for the serial port clock derivation core.
// Types, field constants and the radix-16 divider step. No dependencies.
`default_nettype none
package scfd_pkg;

    localparam int CFG_W      = 32;
    localparam int REF_W      = 26;
    localparam int IDX_W      = 3;
    localparam int DIV_W      = 44;   // dividend width, whole multiple of BITS_PER_STG
    localparam int REM_W      = 15;   // holds any divisor up to 16384
    localparam int BITS_PER_STG = 4;
    localparam int DIV_STAGES = DIV_W / BITS_PER_STG;

    typedef enum logic [IDX_W-1:0] {
        REG_CLOCK_MODE = 3'd0,
        REG_DIVIDER    = 3'd1,
        REG_USB_PLL    = 3'd2,
        REG_SERIAL_PLL = 3'd3,
        REG_REF_HZ     = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_USB    = 2'd1,
        SRC_SERIAL = 2'd2,
        SRC_OTHER  = 2'd3
    } t_src;

    localparam logic [CFG_W-1:0] RST_CLOCK_MODE = 32'h074B0B7B;
    localparam logic [CFG_W-1:0] RST_DIVIDER    = 32'h49FCFE7F;
    localparam logic [CFG_W-1:0] RST_USB_PLL    = 32'h04051C03;
    localparam logic [CFG_W-1:0] RST_SERIAL_PLL = 32'h04043001;
    localparam logic [REF_W-1:0] RST_REF_HZ     = 26'd27000000;
    localparam logic [3:0]       MFI_MIN        = 4'd5;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } t_div;

    typedef struct packed {
        logic vld;
        logic port;
        logic use_usb;
        logic neg;
        t_div div;
    } t_d1;

    typedef struct packed {
        logic vld;
        logic port;
        t_div div;
    } t_d2;

    // Four restoring-division steps; quo shifts out dividend bits, in quotient bits.
    function automatic t_div div_step(t_div s, logic [REM_W-1:0] den);
        t_div       r;
        logic [REM_W:0] t;
        r = s;
        for (int i = 0; i < BITS_PER_STG; i++) begin
            t = {r.rem, r.quo[DIV_W-1]};
            r.quo = {r.quo[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                r.rem    = REM_W'(t - {1'b0, den});
                r.quo[0] = 1'b1;
            end else begin
                r.rem = t[REM_W-1:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/ssi_clock_frequency_derivation_core.sv
// Serial audio port clock derivation core (top level).
// Depends on scfd_pkg for types, constants and the divider step.
`default_nettype none
// Each item names one of two serial ports; the result is that port's clock
// in Hz. Source 1 is the USB PLL through its pre/post dividers, source 2 the
// serial PLL; sources 0 and 3 return zero with the unsupported flag set.
// A PLL gives 2*ref*(MFI*MFD+MFN)/(MFD*PD), truncated toward zero, low 32
// bits kept. The core is a 26-stage pipeline: two stages form the PLL
// numerator (one multiplier each), eleven stages divide it by MFD*PD at four
// quotient bits per stage, one stage applies the sign, eleven more divide by
// the port (and USB) divider product, and an output register holds the
// result. One item is accepted every cycle unless the pipe holds. When the
// output is stalled the whole pipe holds. Configuration must be written only
// while no item is in flight; the stages read the registers directly.
module ssi_clock_frequency_derivation_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_ssi_port,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_clock_hz,
    output logic             o_unsupported,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int NS = scfd_pkg::DIV_STAGES;
    localparam int RW = scfd_pkg::REM_W;

    // configuration registers
    logic [31:0] r_mode, r_div, r_usb, r_ser;
    logic [25:0] r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= scfd_pkg::RST_CLOCK_MODE;
            r_div  <= scfd_pkg::RST_DIVIDER;
            r_usb  <= scfd_pkg::RST_USB_PLL;
            r_ser  <= scfd_pkg::RST_SERIAL_PLL;
            r_ref  <= scfd_pkg::RST_REF_HZ;
        end else if (i_cfg_we) begin
            case (scfd_pkg::t_reg_idx'(i_cfg_idx))
                scfd_pkg::REG_CLOCK_MODE: r_mode <= i_cfg_data;
                scfd_pkg::REG_DIVIDER:    r_div  <= i_cfg_data;
                scfd_pkg::REG_USB_PLL:    r_usb  <= i_cfg_data;
                scfd_pkg::REG_SERIAL_PLL: r_ser  <= i_cfg_data;
                scfd_pkg::REG_REF_HZ:     r_ref  <= i_cfg_data[25:0];
                default: ;  // index beyond the list: ignored
            endcase
        end
    end

    // per-port decode of source and divider product (pre*post up to 512)
    logic [1:0]  w_sel  [2];
    logic [9:0]  w_pp   [2];
    logic [5:0]  w_usbdiv;
    logic [RW-1:0] w_d2 [2];
    logic        w_unsup[2];

    assign w_sel[0] = r_mode[19:18];
    assign w_sel[1] = r_mode[22:21];
    assign w_pp[0]  = 10'({1'b0, r_div[8:6]} + 4'd1) * 10'({1'b0, r_div[5:0]} + 7'd1);
    assign w_pp[1]  = 10'({1'b0, r_div[17:15]} + 4'd1) * 10'({1'b0, r_div[14:9]} + 7'd1);
    assign w_usbdiv = 6'({1'b0, r_div[31:30]} + 3'd1) * 6'({1'b0, r_div[29:27]} + 4'd1);

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_unsup[p] = (scfd_pkg::t_src'(w_sel[p]) != scfd_pkg::SRC_USB) &&
                         (scfd_pkg::t_src'(w_sel[p]) != scfd_pkg::SRC_SERIAL);
            if (scfd_pkg::t_src'(w_sel[p]) == scfd_pkg::SRC_USB) begin
                w_d2[p] = RW'(w_pp[p] * w_usbdiv);
            end else begin
                w_d2[p] = RW'(w_pp[p]);
            end
        end
    end

    // PLL denominators MFD*PD
    logic [RW-1:0] w_den_usb, w_den_ser;
    assign w_den_usb = RW'({1'b0, r_usb[25:16]} + 11'd1) * RW'({1'b0, r_usb[29:26]} + 5'd1);
    assign w_den_ser = RW'({1'b0, r_ser[25:16]} + 11'd1) * RW'({1'b0, r_ser[29:26]} + 5'd1);

    // pipe advances unless the output holds an untaken result
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: MFI*MFD
    logic        r_s1_vld, r_s1_port, r_s1_usb;
    logic [13:0] r_s1_base;
    logic [31:0] w_ctl_in;
    logic        w_usb_in;
    logic [3:0]  w_mfi;

    assign w_usb_in = scfd_pkg::t_src'(w_sel[i_ssi_port]) == scfd_pkg::SRC_USB;
    assign w_ctl_in = w_usb_in ? r_usb : r_ser;
    assign w_mfi    = (w_ctl_in[13:10] < scfd_pkg::MFI_MIN) ? scfd_pkg::MFI_MIN
                                                             : w_ctl_in[13:10];

    // stage 2: numerator 2*ref*|MFI*MFD+MFN|
    logic        r_s2_vld, r_s2_port, r_s2_usb, r_s2_neg;
    logic [40:0] r_s2_mag;
    logic [31:0] w_ctl_s1;
    logic [9:0]  w_sub;
    logic [13:0] w_mag1;
    logic        w_neg1;

    assign w_ctl_s1 = r_s1_usb ? r_usb : r_ser;
    assign w_sub    = 10'h000 - w_ctl_s1[9:0];  // magnitude when MFN negative

    always_comb begin
        w_neg1 = 1'b0;
        if (w_ctl_s1[9]) begin
            if ({4'd0, w_sub} > r_s1_base) begin
                w_mag1 = {4'd0, w_sub} - r_s1_base;
                w_neg1 = 1'b1;
            end else begin
                w_mag1 = r_s1_base - {4'd0, w_sub};
            end
        end else begin
            w_mag1 = r_s1_base + {4'd0, w_ctl_s1[9:0]};
        end
    end

    // divider 1 (by MFD*PD), divider 2 (by port divider product)
    scfd_pkg::t_d1 r_d1 [NS];
    scfd_pkg::t_d2 r_d2 [NS];
    scfd_pkg::t_div w_d1_in [NS];
    scfd_pkg::t_div w_d2_in [NS];

    // sign stage between the dividers
    logic        r_s3_vld, r_s3_port;
    logic [31:0] r_s3_q;

    always_comb begin
        w_d1_in[0] = '{rem: '0, quo: {3'd0, r_s2_mag}};
        w_d2_in[0] = '{rem: '0, quo: {12'd0, r_s3_q}};
        for (int k = 1; k < NS; k++) begin
            w_d1_in[k] = r_d1[k-1].div;
            w_d2_in[k] = r_d2[k-1].div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            o_valid  <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_d1[k].vld <= 1'b0;
                r_d2[k].vld <= 1'b0;
            end
        end else if (w_en) begin
            r_s1_vld  <= i_valid;
            r_s1_port <= i_ssi_port;
            r_s1_usb  <= w_usb_in;
            r_s1_base <= 14'({10'd0, w_mfi} * ({4'd0, w_ctl_in[25:16]} + 14'd1));

            r_s2_vld  <= r_s1_vld;
            r_s2_port <= r_s1_port;
            r_s2_usb  <= r_s1_usb;
            r_s2_neg  <= w_neg1;
            r_s2_mag  <= {40'(r_ref * w_mag1), 1'b0};

            r_d1[0].vld     <= r_s2_vld;
            r_d1[0].port    <= r_s2_port;
            r_d1[0].use_usb <= r_s2_usb;
            r_d1[0].neg     <= r_s2_neg;
            r_d1[0].div     <= scfd_pkg::div_step(w_d1_in[0],
                                   r_s2_usb ? w_den_usb : w_den_ser);
            for (int k = 1; k < NS; k++) begin
                r_d1[k].vld     <= r_d1[k-1].vld;
                r_d1[k].port    <= r_d1[k-1].port;
                r_d1[k].use_usb <= r_d1[k-1].use_usb;
                r_d1[k].neg     <= r_d1[k-1].neg;
                r_d1[k].div     <= scfd_pkg::div_step(w_d1_in[k],
                                       r_d1[k-1].use_usb ? w_den_usb : w_den_ser);
            end

            // low 32 bits, negated for a negative numerator
            r_s3_vld  <= r_d1[NS-1].vld;
            r_s3_port <= r_d1[NS-1].port;
            r_s3_q    <= r_d1[NS-1].neg ? 32'h0 - r_d1[NS-1].div.quo[31:0]
                                        : r_d1[NS-1].div.quo[31:0];

            r_d2[0].vld  <= r_s3_vld;
            r_d2[0].port <= r_s3_port;
            r_d2[0].div  <= scfd_pkg::div_step(w_d2_in[0], w_d2[r_s3_port]);
            for (int k = 1; k < NS; k++) begin
                r_d2[k].vld  <= r_d2[k-1].vld;
                r_d2[k].port <= r_d2[k-1].port;
                r_d2[k].div  <= scfd_pkg::div_step(w_d2_in[k], w_d2[r_d2[k-1].port]);
            end

            o_valid       <= r_d2[NS-1].vld;
            o_unsupported <= w_unsup[r_d2[NS-1].port];
            o_clock_hz    <= w_unsup[r_d2[NS-1].port] ? 32'd0 : r_d2[NS-1].div.quo[31:0];
        end
    end

endmodule
`default_nettype wire

// File: test/tb_ssi_clock_frequency_derivation_core.sv
// Testbench for ssi_clock_frequency_derivation_core: directed and random port
// queries under several register settings, checked against a local predictor.
// Depends on scfd_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_ssi_clock_frequency_derivation_core;

    localparam int NUM_REGS  = 5;
    localparam int LATENCY   = 26;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [31:0] hz;
        logic        unsup;
    } t_port_clk;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_ssi_port;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_clock_hz;
    logic        o_unsupported;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    // Local copy of the register file, as the predictor sees it
    logic [31:0] mode_word;
    logic [31:0] div_word;
    logic [31:0] usb_ctl;
    logic [31:0] ser_ctl;
    logic [25:0] ref_freq;

    t_port_clk clk_expected[$];
    int        errors;
    bit        idle_en;     // random gaps on both sides
    bit        hold_req;    // ask the receiver for one long hold-off

    ssi_clock_frequency_derivation_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ssi_port    (i_ssi_port),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_clock_hz    (o_clock_hz),
        .o_unsupported (o_unsupported),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // PLL output: 2*ref*(MFI*MFD+MFN)/(MFD*PD), truncated toward zero, low 32 bits
    function automatic logic [31:0] pll_hz(logic [31:0] ctl, logic [25:0] rf);
        logic [63:0] pd, mfd, mfi, base, sub, mag, q;
        logic [9:0]  mfn;
        logic        neg;
        pd  = 64'(ctl[29:26]) + 64'd1;
        mfd = 64'(ctl[25:16]) + 64'd1;
        mfi = 64'(ctl[13:10]);
        if (mfi < 64'(scfd_pkg::MFI_MIN)) mfi = 64'(scfd_pkg::MFI_MIN);
        mfn  = ctl[9:0];
        base = mfi * mfd;
        neg  = 1'b0;
        if (mfn[9]) begin
            sub = 64'd1024 - 64'(mfn);
            if (sub > base) begin
                mag = sub - base;
                neg = 1'b1;
            end else begin
                mag = base - sub;
            end
        end else begin
            mag = base + 64'(mfn);
        end
        q = (64'd2 * 64'(rf) * mag) / (mfd * pd);
        if (neg) q = 64'd0 - q;
        return q[31:0];
    endfunction

    function automatic t_port_clk port_clock(logic port);
        t_port_clk     r;
        scfd_pkg::t_src sel;
        logic [31:0]   pre, post, src;
        if (!port) begin
            sel  = scfd_pkg::t_src'(mode_word[19:18]);
            pre  = 32'(div_word[8:6]) + 1;
            post = 32'(div_word[5:0]) + 1;
        end else begin
            sel  = scfd_pkg::t_src'(mode_word[22:21]);
            pre  = 32'(div_word[17:15]) + 1;
            post = 32'(div_word[14:9]) + 1;
        end
        r.hz    = '0;
        r.unsup = 1'b1;
        if (sel == scfd_pkg::SRC_USB || sel == scfd_pkg::SRC_SERIAL) begin
            if (sel == scfd_pkg::SRC_USB)
                src = pll_hz(usb_ctl, ref_freq)
                      / ((32'(div_word[31:30]) + 1) * (32'(div_word[29:27]) + 1));
            else
                src = pll_hz(ser_ctl, ref_freq);
            r.hz    = src / (pre * post);
            r.unsup = 1'b0;
        end
        return r;
    endfunction

    // Receiver stall: random short bursts, or one long hold on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_port_clk e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (clk_expected.size() == 0) begin
                $display("%0t: unexpected result hz=%0d unsup=%0b",
                         $time, o_clock_hz, o_unsupported);
                errors++;
            end else begin
                e = clk_expected.pop_front();
                if (o_clock_hz !== e.hz) begin
                    $display("%0t: clock_hz expected %0d actual %0d", $time, e.hz, o_clock_hz);
                    errors++;
                end
                if (o_unsupported !== e.unsup) begin
                    $display("%0t: unsupported expected %0b actual %0b",
                             $time, e.unsup, o_unsupported);
                    errors++;
                end
            end
        end
    end

    // Send one query; the expectation is taken at the accepting edge
    task automatic send_query(logic port);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_ssi_port <= port;
        do @(posedge i_clk); while (o_stall);
        clk_expected.push_back(port_clock(port));
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (clk_expected.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only with the pipe empty
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        wait_results_done();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
        if (idx < NUM_REGS) begin
            case (scfd_pkg::t_reg_idx'(idx))
                scfd_pkg::REG_CLOCK_MODE: mode_word = data;
                scfd_pkg::REG_DIVIDER:    div_word  = data;
                scfd_pkg::REG_USB_PLL:    usb_ctl   = data;
                scfd_pkg::REG_SERIAL_PLL: ser_ctl   = data;
                default:                  ref_freq  = data[25:0];
            endcase
        end
    endtask

    task automatic set_sources(scfd_pkg::t_src s0, scfd_pkg::t_src s1);
        logic [31:0] m;
        m = mode_word;
        m[19:18] = s0;
        m[22:21] = s1;
        write_reg(scfd_pkg::REG_CLOCK_MODE, m);
    endtask

    // Reset values, both ports
    task automatic test_reset_values();
        send_query(1'b0);
        send_query(1'b1);
    endtask

    // Every source on both ports, plus writes beyond the register list
    task automatic test_sources();
        for (int s = 0; s < 4; s++) begin
            set_sources(scfd_pkg::t_src'(s), scfd_pkg::t_src'(3 - s));
            send_query(1'b0);
            send_query(1'b1);
        end
        for (int k = NUM_REGS; k < 8; k++) write_reg(3'(k), 32'hFFFF_FFFF);
        send_query(1'b0);
        send_query(1'b1);
    endtask

    // Field extremes: divider maxima, negative numerator, zero and max reference
    task automatic test_extremes();
        set_sources(scfd_pkg::SRC_USB, scfd_pkg::SRC_SERIAL);
        write_reg(scfd_pkg::REG_DIVIDER, 32'hFFFF_FFFF);
        write_reg(scfd_pkg::REG_USB_PLL, 32'hFFFF_FFFF);
        write_reg(scfd_pkg::REG_SERIAL_PLL, 32'h0000_0200);   // MFN = -512, MFD = 1
        write_reg(scfd_pkg::REG_REF_HZ, 32'hFFFF_FFFF);        // upper bits dropped
        send_query(1'b0);
        send_query(1'b1);
        write_reg(scfd_pkg::REG_DIVIDER, 32'h0);
        write_reg(scfd_pkg::REG_USB_PLL, 32'h0000_03FF);       // MFN = -1, MFI raised to 5
        write_reg(scfd_pkg::REG_SERIAL_PLL, 32'h3FFF_FDFF);    // all max, MFN most positive
        send_query(1'b0);
        send_query(1'b1);
        write_reg(scfd_pkg::REG_REF_HZ, 32'h0);                // zero reference
        send_query(1'b0);
        send_query(1'b1);
        write_reg(scfd_pkg::REG_REF_HZ, 32'd1);
        write_reg(scfd_pkg::REG_USB_PLL, 32'h0000_0200);
        send_query(1'b0);
        send_query(1'b1);
    endtask

    task automatic random_config();
        logic [31:0] pll_mask;
        // half the time keep MFD small so negative numerators show up
        pll_mask = ($urandom_range(0, 1) != 0) ? 32'hFC07_FFFF : 32'hFFFF_FFFF;
        write_reg(scfd_pkg::REG_CLOCK_MODE, $urandom());
        write_reg(scfd_pkg::REG_DIVIDER, $urandom());
        write_reg(scfd_pkg::REG_USB_PLL, $urandom() & pll_mask);
        write_reg(scfd_pkg::REG_SERIAL_PLL, $urandom() & pll_mask);
        case ($urandom_range(0, 3))
            0:       write_reg(scfd_pkg::REG_REF_HZ, 32'd27000000);
            1:       write_reg(scfd_pkg::REG_REF_HZ, 32'(26'h3FF_FFFF));
            default: write_reg(scfd_pkg::REG_REF_HZ, $urandom());
        endcase
        // keep most phases on supported sources
        if ($urandom_range(0, 3) != 0)
            set_sources(scfd_pkg::t_src'($urandom_range(1, 2)),
                        scfd_pkg::t_src'($urandom_range(1, 2)));
    endtask

    // Random phases; with idle_en set, the receiver holds off once while queries keep coming
    task automatic test_random(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            random_config();
            if (p == 2 && idle_en) hold_req = 1'b1;
            for (int n = 0; n < per_phase; n++) send_query(1'($urandom_range(0, 1)));
        end
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 40; n++) send_query(1'($urandom_range(0, 1)));
        wait_results_done();
        for (int n = 0; n < 40; n++) send_query(1'($urandom_range(0, 1)));
    endtask

    initial begin
        errors     = 0;
        idle_en    = 1'b0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ssi_port = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = scfd_pkg::REG_CLOCK_MODE;
        i_cfg_data = '0;
        mode_word  = scfd_pkg::RST_CLOCK_MODE;
        div_word   = scfd_pkg::RST_DIVIDER;
        usb_ctl    = scfd_pkg::RST_USB_PLL;
        ser_ctl    = scfd_pkg::RST_SERIAL_PLL;
        ref_freq   = scfd_pkg::RST_REF_HZ;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_sources();
        test_extremes();
        idle_en = 1'b1;
        test_random(17, 100);
        test_drain_pause();
        idle_en = 1'b0;            // closing stretch runs back to back
        test_random(3, 100);

        wait_results_done();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
